// ----- design/urxto_pkg.sv -----
// ----------------------------------------------------------------------------
// urxto_pkg
// Shared types and constants of the serial receiver with start timeout.
// ----------------------------------------------------------------------------
package urxto_pkg;

  localparam int unsigned DATA_BITS = 8;

  localparam int unsigned BIT_PERIOD_W = 16;
  localparam int unsigned TIMEOUT_W    = 24;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned BIT_INDEX_W  = 4;
  localparam int unsigned BYTE_W       = 8;

  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 16'd104;
  localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RST    = 24'd20000;

  // configuration register indexes
  localparam logic CFG_BIT_PERIOD = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  // item kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_START  = 3'd2,
    PH_DATA   = 3'd3,
    PH_STOP   = 3'd4,
    PH_FINISH = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TIMEOUT     = 2'd1,
    ST_FALSE_START = 2'd2,
    ST_FRAMING     = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    status_t           status;
  } result_t;

endpackage

// ----- design/uart_receiver_with_timeout.sv -----
// ----------------------------------------------------------------------------
// uart_receiver_with_timeout
// Tick-driven 8N1 serial receiver with start-bit timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction per sampling tick. tuser is the command
//   (0 = tick with line sample, 1 = arm a receive); tdata bit 0 is the
//   sampled line level. Arm once, then feed ticks.
//   Master stream: one transaction per finished reception: tdata is the
//   byte (zero on error), tuser the status (ok, timeout, false start,
//   framing error).
//   Config port: cfg_we with cfg_addr 0 writes the bit period in ticks,
//   cfg_addr 1 the start timeout in ticks (0 waits forever).
//   Result path: the tick that ends the reception passes the input register,
//   then its result is registered in the output register on the master side.
//   Throughput: 1 transaction per cycle unless a finishing tick waits for a
//   held result, set by the sequencer step between input and output register.
//   Reset: the receiver is idle and not armed; registers hold 104 and 20000.
//   Stall: ticks that give no result keep flowing while a result waits; a
//   tick that finishes a reception waits until the held result is taken.
// ----------------------------------------------------------------------------
module uart_receiver_with_timeout (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [0] rx_level
  input  logic                                s_axis_tuser,   // [0] cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] data_byte
  output logic [1:0]                          m_axis_tuser,   // [1:0] status
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [urxto_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                                 in_valid;
  logic                                 in_cmd;
  logic                                 in_rx;
  logic                                 out_valid;
  logic [urxto_pkg::BYTE_W-1:0]         out_data;
  urxto_pkg::status_t                   out_status;
  logic [urxto_pkg::BIT_PERIOD_W-1:0]   bit_period;
  logic [urxto_pkg::TIMEOUT_W-1:0]      timeout_ticks;
  urxto_pkg::result_t                   res;
  logic                                 step;

  // a result-producing tick may only advance when the output slot frees up
  assign step = in_valid && (!res.valid || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period    <= urxto_pkg::BIT_PERIOD_RST;
      timeout_ticks <= urxto_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        urxto_pkg::CFG_BIT_PERIOD: bit_period <= cfg_wdata[urxto_pkg::BIT_PERIOD_W-1:0];
        urxto_pkg::CFG_TIMEOUT:    timeout_ticks <= cfg_wdata[urxto_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd <= s_axis_tuser;
      in_rx  <= s_axis_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_data   <= res.data;
      out_status <= res.status;
    end
  end

  urxto_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .cmd           (in_cmd),
    .rx_level      (in_rx),
    .bit_period    (bit_period),
    .timeout_ticks (timeout_ticks),
    .res           (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

endmodule

// ----- design/urxto_core.sv -----
// ----------------------------------------------------------------------------
// urxto_core
// Receive sequencer: start detect, timeout, mid-bit sampling and stop check.
// ----------------------------------------------------------------------------
module urxto_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic                                 cmd,
  input  logic                                 rx_level,
  input  logic [urxto_pkg::BIT_PERIOD_W-1:0]   bit_period,
  input  logic [urxto_pkg::TIMEOUT_W-1:0]      timeout_ticks,
  output urxto_pkg::result_t                   res
);

  urxto_pkg::phase_t                     phase, phase_next;
  logic [urxto_pkg::BIT_PERIOD_W-1:0]    wait_count, wait_count_next;
  logic [urxto_pkg::TIMEOUT_W-1:0]       timeout_count, timeout_count_next;
  logic [urxto_pkg::BIT_INDEX_W-1:0]     bit_index, bit_index_next;
  logic [urxto_pkg::BYTE_W-1:0]          shift_data, shift_data_next;
  urxto_pkg::status_t                    pending_status, pending_status_next;
  logic [urxto_pkg::BIT_PERIOD_W-1:0]    half;

  assign half = bit_period >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= urxto_pkg::PH_IDLE;
      wait_count     <= '0;
      timeout_count  <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      pending_status <= urxto_pkg::ST_OK;
    end else if (step) begin
      phase          <= phase_next;
      wait_count     <= wait_count_next;
      timeout_count  <= timeout_count_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      pending_status <= pending_status_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    wait_count_next     = wait_count;
    timeout_count_next  = timeout_count;
    bit_index_next      = bit_index;
    shift_data_next     = shift_data;
    pending_status_next = pending_status;
    res.valid           = 1'b0;
    res.data            = '0;
    res.status          = urxto_pkg::ST_OK;

    if (cmd == urxto_pkg::CMD_ARM) begin
      phase_next          = urxto_pkg::PH_WAIT;
      timeout_count_next  = timeout_ticks;
      wait_count_next     = '0;
      bit_index_next      = '0;
      shift_data_next     = '0;
      pending_status_next = urxto_pkg::ST_OK;
    end else if (phase == urxto_pkg::PH_IDLE) begin
      phase_next = urxto_pkg::PH_IDLE;
    end else if (phase == urxto_pkg::PH_WAIT) begin
      if (!rx_level) begin
        phase_next      = urxto_pkg::PH_START;
        wait_count_next = half;
      end else if (timeout_ticks != '0) begin
        if (timeout_count == '0) begin
          phase_next = urxto_pkg::PH_IDLE;
          res.valid  = 1'b1;
          res.status = urxto_pkg::ST_TIMEOUT;
        end else begin
          timeout_count_next = timeout_count - 1'b1;
        end
      end
    end else if (wait_count > 16'd1) begin
      wait_count_next = wait_count - 1'b1;
    end else begin
      wait_count_next = '0;
      unique case (phase)
        urxto_pkg::PH_START: begin
          if (rx_level) begin
            pending_status_next = urxto_pkg::ST_FALSE_START;
            phase_next          = urxto_pkg::PH_FINISH;
            wait_count_next     = half;
          end else begin
            bit_index_next  = '0;
            shift_data_next = '0;
            phase_next      = urxto_pkg::PH_DATA;
            wait_count_next = bit_period;
          end
        end
        urxto_pkg::PH_DATA: begin
          // a set bit is stored at its bit index; only indexes below the byte width are stored
          if (rx_level && (bit_index < 4'(urxto_pkg::BYTE_W)))
            shift_data_next = shift_data | (8'd1 << bit_index[2:0]);
          bit_index_next = bit_index + 1'b1;
          if ((bit_index + 1'b1) >= 4'(urxto_pkg::DATA_BITS))
            phase_next = urxto_pkg::PH_STOP;
          wait_count_next = bit_period;
        end
        urxto_pkg::PH_STOP: begin
          pending_status_next = rx_level ? urxto_pkg::ST_OK : urxto_pkg::ST_FRAMING;
          phase_next          = urxto_pkg::PH_FINISH;
          wait_count_next     = half;
        end
        urxto_pkg::PH_FINISH: begin
          res.valid  = 1'b1;
          res.data   = (pending_status == urxto_pkg::ST_OK) ? shift_data : '0;
          res.status = pending_status;
          phase_next = urxto_pkg::PH_IDLE;
        end
        default: begin
          phase_next = urxto_pkg::PH_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_res_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (phase == urxto_pkg::PH_WAIT || phase == urxto_pkg::PH_FINISH))
    else $error("result outside wait or finish phase");

  a_timeout_from_wait: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == urxto_pkg::ST_TIMEOUT) |-> (phase == urxto_pkg::PH_WAIT))
    else $error("timeout reported outside wait phase");

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'(urxto_pkg::DATA_BITS))
    else $error("bit index past data width");

  a_arm: assert property (@(posedge clk) disable iff (rst)
    (step && cmd == urxto_pkg::CMD_ARM) |=> (phase == urxto_pkg::PH_WAIT && bit_index == '0))
    else $error("arm did not restart reception");
`endif

endmodule
